// ===== rtl/core/frs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the frame synchroniser.
package frs_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int TIME_W   = 48;
    localparam int TAG_W    = 32;
    localparam int PERIOD_W = 24;
    localparam int RATE_W   = 20;
    localparam int TICK_W   = 32;

    // Media time arithmetic: ticks * den * CLK_RATE, then divide by num
    localparam int PROD_W  = TICK_W + RATE_W;    // 52
    localparam int HALF_W  = PROD_W / 2;         // 26
    localparam int RATEC_W = 18;
    localparam int PP_W    = HALF_W + RATEC_W;   // 44
    localparam int MEDIA_W = PROD_W + RATEC_W;   // 70
    localparam int STEP_W  = $clog2(MEDIA_W);
    localparam logic [RATEC_W-1:0] CLK_RATE = RATEC_W'(180000);

    // Input item kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ARRIVAL = 2'd0;
    localparam t_kind KIND_TICK    = 2'd1;
    localparam t_kind KIND_FLUSH   = 2'd2;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_EMITTED = 3'd0;
    localparam t_status ST_NO_REF  = 3'd1;
    localparam t_status ST_MISSING = 3'd2;
    localparam t_status ST_STORED  = 3'd3;
    localparam t_status ST_DROPPED = 3'd4;
    localparam t_status ST_FLUSHED = 3'd5;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAME_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_WINDOW       = 2'd1;
    localparam t_cfg_idx CFG_RATE_NUM     = 2'd2;
    localparam t_cfg_idx CFG_RATE_DEN     = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic    load;        // latch input beat, set prune limit
        logic    flush;
        logic    walk_init;
        logic    walk;        // one prune step
        logic    commit;      // finish prune pass
        logic    store;
        logic    sel_init;
        logic    sel_step;
        logic    lim_post;    // prune limit from chosen frame
        logic    media_start;
        logic    tick_inc;
        logic    emit;
        t_status status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_end;
        logic full;
        logic found;
        logic tick_nz;
        logic flushing;
        logic media_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/frs_mdiv.sv =====
// Media time unit: ticks*den*180000/num with saturation, by shift-and-subtract division.
module frs_mdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [frs_pkg::TICK_W-1:0]    i_ticks,
    input  logic [frs_pkg::RATE_W-1:0]    i_den,
    input  logic [frs_pkg::RATE_W-1:0]    i_num,
    output logic                          o_done,
    output logic [frs_pkg::TIME_W-1:0]    o_media
);
    import frs_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_MUL1, M_MUL2, M_ADD, M_DIV, M_DONE
    } t_mstate;

    t_mstate              r_state, n_state;
    logic [TICK_W-1:0]    r_ticks;
    logic [RATE_W-1:0]    r_den;
    logic [RATE_W-1:0]    r_num;
    logic [PROD_W-1:0]    r_prod;
    logic [PP_W-1:0]      r_pp_hi;
    logic [PP_W-1:0]      r_pp_lo;
    logic [MEDIA_W-1:0]   r_acc;
    logic [RATE_W-1:0]    r_rem;
    logic [STEP_W-1:0]    r_step;
    logic [TIME_W-1:0]    r_media;

    logic [RATE_W:0]      trial;
    logic                 take;

    // One quotient bit per cycle
    assign trial = {r_rem, r_acc[MEDIA_W-1]};
    assign take  = trial >= {1'b0, r_num};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE:  if (i_start) n_state = M_MUL1;
            M_MUL1:  n_state = M_MUL2;
            M_MUL2:  n_state = M_ADD;
            M_ADD:   n_state = M_DIV;
            M_DIV:   if (r_step == STEP_W'(MEDIA_W - 1)) n_state = M_DONE;
            M_DONE:  n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath of the unit
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_ticks <= i_ticks;
                    r_den   <= i_den;
                    // zero numerator counts as one
                    r_num   <= (i_num == '0) ? RATE_W'(1) : i_num;
                end
            end
            M_MUL1: begin
                r_prod <= PROD_W'(r_ticks) * PROD_W'(r_den);
            end
            M_MUL2: begin
                r_pp_hi <= PP_W'(r_prod[PROD_W-1:HALF_W]) * PP_W'(CLK_RATE);
                r_pp_lo <= PP_W'(r_prod[HALF_W-1:0]) * PP_W'(CLK_RATE);
            end
            M_ADD: begin
                r_acc  <= {r_pp_hi, {HALF_W{1'b0}}} + MEDIA_W'(r_pp_lo);
                r_rem  <= '0;
                r_step <= '0;
            end
            M_DIV: begin
                r_rem  <= take ? RATE_W'(trial - {1'b0, r_num}) : trial[RATE_W-1:0];
                r_acc  <= {r_acc[MEDIA_W-2:0], take};
                r_step <= r_step + STEP_W'(1);
            end
            M_DONE: begin
                r_media <= (|r_acc[MEDIA_W-1:TIME_W]) ? {TIME_W{1'b1}} : r_acc[TIME_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_done  = (r_state == M_IDLE) && (r_step == STEP_W'(MEDIA_W)) ? 1'b0 :
                     (r_state == M_DONE);
    assign o_media = r_media;

endmodule

// ===== rtl/core/frs_datapath.sv =====
// Datapath: frame queue, prune and selection walks, configuration, media unit, result register.
module frs_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  frs_pkg::t_cmd         i_cmd,
    output frs_pkg::t_sts         o_sts,
    input  logic [127:0]          i_in_data,
    input  frs_pkg::t_kind        i_in_kind,
    input  logic                  i_cfg_valid,
    input  frs_pkg::t_cfg_idx     i_cfg_index,
    input  logic [47:0]           i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [127:0]          o_out_data,
    output frs_pkg::t_status      o_out_status
);
    import frs_pkg::*;

    // Queue store
    logic [TIME_W-1:0]   r_q_clk [QUEUE_DEPTH];
    logic [TAG_W-1:0]    r_q_tag [QUEUE_DEPTH];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_wr;

    // Item and walk state
    logic [TIME_W-1:0]   r_item;
    logic [TAG_W-1:0]    r_tag;
    logic signed [TIME_W:0] r_limit;
    logic [TIME_W:0]     r_best;
    logic                r_found;
    logic [TIME_W-1:0]   r_sel_clk;
    logic [TAG_W-1:0]    r_sel_tag;
    logic [TICK_W-1:0]   r_tick;
    logic                r_flushing;

    // Configuration
    logic [PERIOD_W-1:0] r_period;
    logic [TIME_W-1:0]   r_window;
    logic [RATE_W-1:0]   r_num;
    logic [RATE_W-1:0]   r_den;

    // Result register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [TAG_W-1:0]    r_out_tag;
    logic [TIME_W-1:0]   r_out_clk;
    logic [TIME_W-1:0]   r_out_med;

    logic [IDX_W-1:0]    rd_addr;
    logic [TIME_W-1:0]   rd_clk;
    logic [TAG_W-1:0]    rd_tag;
    logic                old;
    logic signed [TIME_W:0] diff;
    logic [TIME_W:0]     adist;
    logic                better;
    logic [TIME_W-1:0]   in_item;
    logic [TIME_W-1:0]   in_now;
    logic [TIME_W-1:0]   lim_src;
    logic                keep_last;
    logic                media_done;
    logic [TIME_W-1:0]   media;

    assign in_item = i_in_data[47:0];
    assign in_now  = i_in_data[95:48];
    assign lim_src = (i_in_kind == KIND_ARRIVAL) ? in_now : in_item;

    // Single read port: the commit step reads the last entry
    assign rd_addr = i_cmd.commit ? IDX_W'(r_count - CNT_W'(1)) : r_idx[IDX_W-1:0];
    assign rd_clk  = r_q_clk[rd_addr];
    assign rd_tag  = r_q_tag[rd_addr];

    assign old    = $signed({1'b0, rd_clk}) < r_limit;
    assign diff   = $signed({1'b0, rd_clk}) - $signed({1'b0, r_item});
    assign adist  = diff[TIME_W] ? (TIME_W+1)'(-diff) : diff;
    assign better = (adist < r_best) &&
                    (diff <= 0 || r_best > (TIME_W+1)'(r_period));
    assign keep_last = (r_wr == '0) && (r_count != '0) && !r_flushing;

    // Queue contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk && !old) begin
            r_q_clk[r_wr[IDX_W-1:0]] <= rd_clk;
            r_q_tag[r_wr[IDX_W-1:0]] <= rd_tag;
        end else if (i_cmd.commit && keep_last) begin
            r_q_clk[0] <= rd_clk;
            r_q_tag[0] <= rd_tag;
        end else if (i_cmd.store && (r_count != CNT_W'(QUEUE_DEPTH))) begin
            r_q_clk[r_count[IDX_W-1:0]] <= r_item;
            r_q_tag[r_count[IDX_W-1:0]] <= r_tag;
        end
    end

    // Control registers of the queue and walks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_tick     <= '0;
            r_flushing <= 1'b0;
            r_idx      <= '0;
            r_wr       <= '0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.flush) begin
                r_flushing <= 1'b1;
                r_count    <= '0;
            end
            if (i_cmd.walk_init || i_cmd.sel_init) begin
                r_idx <= '0;
                r_wr  <= '0;
            end
            if (i_cmd.walk) begin
                r_idx <= r_idx + CNT_W'(1);
                if (!old) r_wr <= r_wr + CNT_W'(1);
            end
            if (i_cmd.commit) r_count <= keep_last ? CNT_W'(1) : r_wr;
            if (i_cmd.store && (r_count != CNT_W'(QUEUE_DEPTH))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.sel_init) r_found <= 1'b0;
            if (i_cmd.sel_step) begin
                r_idx <= r_idx + CNT_W'(1);
                if (better) r_found <= 1'b1;
            end
            if (i_cmd.tick_inc) r_tick <= r_tick + TICK_W'(1);
        end
    end

    // Item, limit and selection payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= in_item;
            r_tag   <= i_in_data[127:96];
            r_limit <= $signed({1'b0, lim_src}) - $signed({1'b0, r_window});
        end
        if (i_cmd.lim_post) r_limit <= $signed({1'b0, r_sel_clk});
        if (i_cmd.sel_init) r_best <= '1;
        if (i_cmd.sel_step && better) begin
            r_best    <= adist;
            r_sel_clk <= rd_clk;
            r_sel_tag <= rd_tag;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_W'(7200);
            r_window <= TIME_W'(180000);
            r_num    <= RATE_W'(25);
            r_den    <= RATE_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_WINDOW:       r_window <= i_cfg_data[TIME_W-1:0];
                CFG_RATE_NUM:     r_num    <= i_cfg_data[RATE_W-1:0];
                CFG_RATE_DEN:     r_den    <= i_cfg_data[RATE_W-1:0];
                default:          r_num    <= r_num;
            endcase
        end
    end

    frs_mdiv u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.media_start),
        .i_ticks (r_tick),
        .i_den   (r_den),
        .i_num   (r_num),
        .o_done  (media_done),
        .o_media (media)
    );

    // Result register, freed when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            if (i_cmd.status == ST_EMITTED) begin
                r_out_tag <= r_sel_tag;
                r_out_clk <= r_sel_clk;
                r_out_med <= media;
            end else begin
                r_out_tag <= '0;
                r_out_clk <= '0;
                r_out_med <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = {r_out_med, r_out_clk, r_out_tag};

    assign o_sts.walk_end   = (r_idx == r_count);
    assign o_sts.full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_sts.found      = r_found;
    assign o_sts.tick_nz    = (r_tick != '0);
    assign o_sts.flushing   = r_flushing;
    assign o_sts.media_done = media_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/core/frs_ctrl.sv =====
// Controller: sequences prune, store, select, media time and result as each beat needs.
module frs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  frs_pkg::t_kind  i_in_kind,
    input  frs_pkg::t_sts   i_sts,
    output frs_pkg::t_cmd   o_cmd
);
    import frs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PRE_PRUNE, S_STORE, S_SELECT, S_MEDIA, S_POST_PRUNE, S_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_kind   r_kind, n_kind;
    t_status r_status, n_status;
    t_cmd    cmd;
    logic    accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_status   = r_status;
        cmd        = '0;
        cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    n_kind   = i_in_kind;
                    if (i_in_kind == KIND_FLUSH) begin
                        cmd.flush = 1'b1;
                        n_status  = ST_FLUSHED;
                        n_state   = S_EMIT;
                    end else if (i_in_kind == KIND_ARRIVAL || i_in_kind == KIND_TICK) begin
                        cmd.walk_init = 1'b1;
                        n_state       = S_PRE_PRUNE;
                    end
                end
            end
            S_PRE_PRUNE: begin
                if (!i_sts.walk_end) begin
                    cmd.walk = 1'b1;
                end else begin
                    cmd.commit = 1'b1;
                    if (r_kind == KIND_ARRIVAL) begin
                        n_state = S_STORE;
                    end else begin
                        cmd.sel_init = 1'b1;
                        n_state      = S_SELECT;
                    end
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                n_status  = i_sts.full ? ST_DROPPED : ST_STORED;
                n_state   = S_EMIT;
            end
            S_SELECT: begin
                if (!i_sts.walk_end) begin
                    cmd.sel_step = 1'b1;
                end else if (!i_sts.found) begin
                    n_status = (i_sts.tick_nz && !i_sts.flushing) ? ST_MISSING : ST_NO_REF;
                    n_state  = S_EMIT;
                end else begin
                    cmd.media_start = 1'b1;
                    cmd.lim_post    = 1'b1;
                    cmd.walk_init   = 1'b1;
                    n_state         = S_MEDIA;
                end
            end
            S_MEDIA: begin
                if (i_sts.media_done) begin
                    cmd.tick_inc = 1'b1;
                    n_state      = S_POST_PRUNE;
                end
            end
            S_POST_PRUNE: begin
                if (!i_sts.walk_end) begin
                    cmd.walk = 1'b1;
                end else begin
                    cmd.commit = 1'b1;
                    n_status   = ST_EMITTED;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= KIND_ARRIVAL;
            r_status <= ST_EMITTED;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_status <= n_status;
        end
    end

    assign o_cmd = cmd;

endmodule

// ===== rtl/core/frame_rate_synchronizer.sv =====
// Top level of the frame rate synchroniser: stream ports, controller and datapath.
//
//  channel  direction  handshake                  payload
//  s_axis   in         s_axis_tvalid/tready       tuser kind, tdata item/now/tag
//  m_axis   out        m_axis_tvalid/tready       tuser status, tdata tag/clock/media
//  cfg      in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One beat at a time. Arrivals and ticks walk the N queued frames (up to
// 16), and a tick that selects a frame also runs the 70-step media time
// division. Reset is synchronous and clears the queue count, tick counter
// and flush flag; configuration returns to its defaults.
// A stalled result holds in the output register while the next beat is taken.
module frame_rate_synchronizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // item_time[47:0], now_time[95:48], frame_tag[127:96]
    input  logic [1:0]    s_axis_tuser,   // kind[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // out_tag[31:0], out_clock_time[79:32],
                                          // out_media_time[127:80]
    output logic [2:0]    m_axis_tuser,   // status[2:0]
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [47:0]   i_cfg_data
);
    import frs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    frs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_kind  (s_axis_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    frs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_data    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule
